// File: design/fpsm_pkg.sv
package fpsm_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_PATTERN_BYTES  = 2'd0;
    localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd1;
    localparam logic [1:0] CFG_CASE_SENSITIVE = 2'd2;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic shift;   // a text byte transfers this cycle
        logic clear;   // that byte ends the text
        logic exact;   // no case folding
    } cell_ctrl_t;

    typedef struct packed {
        logic [31:0] match_start;
        logic [31:0] match_end;
        logic [31:0] match_total;
    } result_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic exact);
        logic [7:0] r;
        r = c;
        if (!exact && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z))
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// File: design/fpsm_cell.sv
module fpsm_cell
    import fpsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       active,
    input  logic [7:0] pattern,
    input  logic [7:0] data_in,
    input  logic       valid_in,
    output logic [7:0] data_out,
    output logic       valid_out,
    output logic       hit
);

    logic [7:0] data_reg;
    logic       valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            data_reg <= data_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= valid_in && !ctrl.clear;
        end
    end

    // Compare against the byte about to be stored (post-shift view)
    assign hit = !active ||
                 (valid_in && (fold_byte(data_in, ctrl.exact) == fold_byte(pattern, ctrl.exact)));

    assign data_out  = data_reg;
    assign valid_out = valid_reg;

endmodule

// File: design/fpsm_out_queue.sv
module fpsm_out_queue
    import fpsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t s0_reg, s0_next;
    result_t s1_reg, s1_next;
    logic    v0_reg, v0_next;
    logic    v1_reg, v1_next;
    logic    pop;

    assign pop = v0_reg && out_ready;

    // push is only offered while the second slot is empty
    always_comb
    begin
        s0_next = s0_reg;
        s1_next = s1_reg;
        v0_next = v0_reg;
        v1_next = v1_reg;
        if (pop)
        begin
            if (v1_reg)
            begin
                s0_next = s1_reg;
                v1_next = 1'b0;
            end
            else if (push)
            begin
                s0_next = push_data;
            end
            else
            begin
                v0_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (v0_reg)
            begin
                s1_next = push_data;
                v1_next = 1'b1;
            end
            else
            begin
                s0_next = push_data;
                v0_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= s0_next;
        s1_reg <= s1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    assign full      = v1_reg;
    assign out_valid = v0_reg;
    assign out_data  = s0_reg;

endmodule

// File: design/fixed_pattern_stream_matcher_top.sv
// Streaming fixed-pattern matcher. Text arrives one byte per transfer on the
// text channel; text_last marks the final byte of a text and resets position,
// history and blockout (the running match_total is kept). The block reports
// leftmost, non-overlapping occurrences of a pattern of 1..MAX_PATTERN bytes
// (pattern_length 0 acts as 1, values above MAX_PATTERN as MAX_PATTERN),
// optionally folding ASCII A-Z to lower case. Each match is one transfer on
// the match channel carrying start, exclusive end and running total.
// Rate: one text byte per cycle while text_ready is high. A row of MAX_PATTERN cells holds
// the byte history and compares every pattern position in the same cycle;
// the match decision is an AND across the row. A result enters the output
// queue with the byte that completes it. A two-entry output queue decouples
// the match channel: text_ready drops only while both entries hold unread
// results. Config: cfg_ready is always high; registers are 0 pattern_bytes,
// 1 pattern_length, 2 case_sensitive; other indexes are ignored. Writes take
// effect for the next byte.
module fixed_pattern_stream_matcher_top
    import fpsm_pkg::*;
#(
    parameter int MAX_PATTERN   = 8,
    parameter int POSITION_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // text channel
    input  logic        text_valid,
    output logic        text_ready,
    input  logic [7:0]  text_byte,
    input  logic        text_last,
    // match channel
    output logic        match_valid,
    input  logic        match_ready,
    output logic [31:0] match_start,
    output logic [31:0] match_end,
    output logic [31:0] match_total,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // Wide enough for MAX_PATTERN itself and for the 4-bit length register
    localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);
    localparam int LW       = (LEN_BITS > 4) ? LEN_BITS : 4;

    // ---------------- configuration registers ----------------
    logic [63:0] pattern_bytes_reg;
    logic [3:0]  pattern_length_reg;
    logic        case_sensitive_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= 4'd1;
            case_sensitive_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[3:0];
                CFG_CASE_SENSITIVE: case_sensitive_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Effective length: zero held at one, clamp at the row length
    logic [LW-1:0] len_ext;
    logic [LW-1:0] eff_len;

    always_comb
    begin
        len_ext = LW'(pattern_length_reg);
        if (len_ext == '0)
        begin
            eff_len = LW'(1);
        end
        else if (len_ext > LW'(MAX_PATTERN))
        begin
            eff_len = LW'(MAX_PATTERN);
        end
        else
        begin
            eff_len = len_ext;
        end
    end

    // ---------------- control state ----------------
    logic                     accept;
    logic                     all_hit;
    logic                     block_active;
    logic                     found;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] end_pos;
    logic [POSITION_BITS-1:0] start_pos;
    logic [LW-1:0]            blockout_reg, blockout_next;
    logic [31:0]              total_reg, total_next;
    logic                     q_full;
    cell_ctrl_t               cell_ctrl;
    result_t                  new_result;
    result_t                  head_result;

    assign accept = text_valid && text_ready;
    assign text_ready = !q_full;

    assign cell_ctrl.shift = accept;
    assign cell_ctrl.clear = text_last;
    assign cell_ctrl.exact = case_sensitive_reg;

    // ---------------- cell row ----------------
    logic [7:0]             cell_data  [MAX_PATTERN];
    logic                   cell_valid [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_hit;

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        logic [LW-1:0] sel;       // pattern index compared in this cell
        logic [7:0]    pat;
        logic [63:0]   shifted;
        logic          active;
        logic [7:0]    d_in;
        logic          v_in;

        assign active  = LW'(k) < eff_len;
        assign sel     = eff_len - LW'(k + 1);
        assign shifted = pattern_bytes_reg >> {sel[2:0], 3'b000};
        // pattern bytes past the 64-bit register read as zero
        assign pat     = (sel >= LW'(8)) ? 8'h00 : shifted[7:0];

        if (k == 0)
        begin : g_head
            assign d_in = text_byte;
            assign v_in = 1'b1;
        end
        else
        begin : g_body
            assign d_in = cell_data[k-1];
            assign v_in = cell_valid[k-1];
        end

        fpsm_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .active    (active),
            .pattern   (pat),
            .data_in   (d_in),
            .valid_in  (v_in),
            .data_out  (cell_data[k]),
            .valid_out (cell_valid[k]),
            .hit       (cell_hit[k])
        );
    end

    assign all_hit      = &cell_hit;
    assign block_active = (blockout_reg != '0);
    assign found        = accept && !block_active && all_hit;

    // positions wrap at POSITION_BITS
    assign end_pos   = pos_reg + POSITION_BITS'(1);
    assign start_pos = end_pos - POSITION_BITS'(eff_len);

    always_comb
    begin
        pos_next      = pos_reg;
        blockout_next = blockout_reg;
        total_next    = total_reg;
        if (accept)
        begin
            pos_next = end_pos;
            if (block_active)
            begin
                blockout_next = blockout_reg - LW'(1);
            end
            else if (all_hit)
            begin
                blockout_next = eff_len - LW'(1);
                total_next    = total_reg + 32'd1;
            end
            if (text_last)
            begin
                pos_next      = '0;
                blockout_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            blockout_reg <= '0;
            total_reg    <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            blockout_reg <= blockout_next;
            total_reg    <= total_next;
        end
    end

    assign new_result.match_start = 32'(start_pos);
    assign new_result.match_end   = 32'(end_pos);
    assign new_result.match_total = total_reg + 32'd1;

    // ---------------- output queue ----------------
    fpsm_out_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (found),
        .push_data (new_result),
        .full      (q_full),
        .out_valid (match_valid),
        .out_ready (match_ready),
        .out_data  (head_result)
    );

    assign match_start = head_result.match_start;
    assign match_end   = head_result.match_end;
    assign match_total = head_result.match_total;

    // ---------------- assertions ----------------
    // end of text clears position and blockout
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text_last |=> (pos_reg == '0) && (blockout_reg == '0))
        else $error("text end did not clear position/blockout");

    // a match mid-text bars the next len-1 bytes
    a_blockout_load: assert property (@(posedge clk) disable iff (!rst_n)
        found && !text_last |=> blockout_reg == ($past(eff_len) - LW'(1)))
        else $error("blockout not loaded after match");

    // after a found match, the queue offers a result on the next cycle
    a_match_offered: assert property (@(posedge clk) disable iff (!rst_n)
        found |=> match_valid)
        else $error("match lost in output queue");

    // input stalls only while results are waiting
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !text_ready |-> match_valid)
        else $error("text stalled with no pending match");

endmodule
